FILE: rtl/idmu_pkg.sv
// ----------------------------------------------------------------------------
// idmu_pkg
// shared types and constants for the integer divide and remainder unit
// ----------------------------------------------------------------------------
`default_nettype none

package idmu_pkg;

  localparam int unsigned DATA_WIDTH = 32;

  // opcode field encoding
  localparam logic [1:0] OP_DIVU = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_REMU = 2'd2;
  localparam logic [1:0] OP_REM  = 2'd3;

  typedef struct packed {
    logic [1:0]            opcode;
    logic [DATA_WIDTH-1:0] dividend;
    logic [DATA_WIDTH-1:0] divisor;
  } idmu_req_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] result;
    logic                  divide_by_zero;
  } idmu_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/integer_divide_modulo_unit.sv
// ----------------------------------------------------------------------------
// integer_divide_modulo_unit
// restoring shift-subtract divider for signed and unsigned quotient/remainder
// ----------------------------------------------------------------------------
// One transaction in, one transaction out. The unit takes one transaction at
// a time: the cycle of acceptance forms the operand magnitudes, then the
// restoring loop retires one quotient bit per cycle until all DATA_WIDTH
// bits are done, and the fix-up state applies the sign and loads the output
// register. The result becomes valid and the input opens again together, so
// a new transaction is taken only once the previous one has left the loop
// and the fix-up state. The loop length is set by the single shared
// subtractor that the partial remainder passes through once per bit. A zero
// divisor skips the loop, goes straight to the fix-up state, raises
// divide_by_zero and returns 0. Signed operations truncate toward zero; the
// most negative value divided by -1 wraps to itself with remainder 0. The
// output register lets a new transaction enter while the previous result
// still waits to be taken; the fix-up cycle stalls only while that older
// result is still held.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_divide_modulo_unit
  import idmu_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire idmu_req_t in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output idmu_rsp_t      out_data_o
);

  localparam int unsigned W    = DATA_WIDTH;
  localparam int unsigned CntW = $clog2(W);

  // state codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_FIX  = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // datapath shift registers: quo holds the dividend bits shifting out and
  // the quotient bits shifting in; rem is the partial remainder
  logic [W-1:0] rem_q, rem_d;
  logic [W-1:0] quo_q, quo_d;
  logic [W-1:0] den_q, den_d;
  logic         is_rem_q, is_rem_d;
  logic         neg_quo_q, neg_quo_d;
  logic         neg_rem_q, neg_rem_d;
  logic         dbz_q, dbz_d;

  logic         out_valid_q, out_valid_d;
  idmu_rsp_t    out_data_q, out_data_d;

  // operand magnitudes formed at acceptance
  logic         a_neg, b_neg;
  logic [W-1:0] a_mag, b_mag;

  // one restoring step
  logic [W:0]   trial;
  logic [W+1:0] diff;
  logic         fits;

  // sign fix-up
  logic [W-1:0] fix_val;
  logic         fix_neg;
  logic [W-1:0] fix_res;

  logic in_fire;
  logic out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // signed opcodes work on magnitudes
  assign a_neg = in_data_i.opcode[0] && in_data_i.dividend[W-1];
  assign b_neg = in_data_i.opcode[0] && in_data_i.divisor[W-1];
  assign a_mag = a_neg ? (~in_data_i.dividend + W'(1)) : in_data_i.dividend;
  assign b_mag = b_neg ? (~in_data_i.divisor + W'(1)) : in_data_i.divisor;

  // shift the next dividend bit into the remainder and try the subtract
  assign trial = {rem_q, quo_q[W-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_q};
  assign fits  = !diff[W+1];

  // quotient takes the xor of the signs, remainder the dividend's sign
  assign fix_val = is_rem_q ? rem_q : quo_q;
  assign fix_neg = is_rem_q ? neg_rem_q : neg_quo_q;
  assign fix_res = dbz_q ? '0 : (fix_neg ? (~fix_val + W'(1)) : fix_val);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    den_d       = den_q;
    is_rem_d    = is_rem_q;
    neg_quo_d   = neg_quo_q;
    neg_rem_d   = neg_rem_q;
    dbz_d       = dbz_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    // result taken downstream
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          rem_d     = '0;
          quo_d     = a_mag;
          den_d     = b_mag;
          cnt_d     = '0;
          is_rem_d  = in_data_i.opcode[1];
          neg_quo_d = a_neg ^ b_neg;
          neg_rem_d = a_neg;
          dbz_d     = (in_data_i.divisor == '0);
          // zero divisor bypasses the loop
          state_d   = (in_data_i.divisor == '0) ? ST_FIX : ST_CALC;
        end
      end
      ST_CALC: begin
        rem_d = fits ? diff[W-1:0] : trial[W-1:0];
        quo_d = {quo_q[W-2:0], fits};
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(W - 1)) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        // wait here while the previous result is still held
        if (out_free) begin
          out_valid_d                = 1'b1;
          out_data_d.result          = fix_res;
          out_data_d.divide_by_zero  = dbz_q;
          state_d                    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    den_q      <= den_d;
    is_rem_q   <= is_rem_d;
    neg_quo_q  <= neg_quo_d;
    neg_rem_q  <= neg_rem_d;
    dbz_q      <= dbz_d;
    out_data_q <= out_data_d;
  end

  // a zero divisor always returns a zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.divide_by_zero) |-> (out_data_q.result == '0))
    else $error("divide by zero with nonzero result");

  // partial remainder stays below the divisor once the loop is done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIX && !dbz_q) |-> (rem_q < den_q))
    else $error("remainder not below divisor");

  // an accepted transaction closes the input until its result is formed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("input reopened right after acceptance");

  // a new result appears only out of the fix-up state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_FIX))
    else $error("result produced outside fix-up");

endmodule

`default_nettype wire
